[src/qau_pkg.sv]
package qau_pkg;

  localparam int QW            = 32;  // component width
  localparam int OPW           = 3;   // opcode width
  localparam int CFG_W         = 16;  // widest config register
  localparam int CFG_IW        = 1;   // config index width
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [OPW-1:0] {
    OP_MUL  = 3'd0,
    OP_CONJ = 3'd1,
    OP_INV  = 3'd2,
    OP_NORM = 3'd3,
    OP_ROT  = 3'd4
  } opcode_t;

  localparam logic [CFG_IW-1:0] CFG_INV_MIN  = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_NORM_MIN = 1'd1;

endpackage

[src/qau_if.sv]
interface qau_in_if import qau_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OPW-1:0]        opcode;
  logic signed [QW-1:0]  a_x;
  logic signed [QW-1:0]  a_y;
  logic signed [QW-1:0]  a_z;
  logic signed [QW-1:0]  a_w;
  logic signed [QW-1:0]  b_x;
  logic signed [QW-1:0]  b_y;
  logic signed [QW-1:0]  b_z;
  logic signed [QW-1:0]  b_w;

  modport source (output valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                  input ready);
  modport sink   (input valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                  output ready);
endinterface

interface qau_out_if import qau_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [QW-1:0]  r_x;
  logic signed [QW-1:0]  r_y;
  logic signed [QW-1:0]  r_z;
  logic signed [QW-1:0]  r_w;
  logic                  ok;
  logic                  saturated;

  modport source (output valid, r_x, r_y, r_z, r_w, ok, saturated, input ready);
  modport sink   (input valid, r_x, r_y, r_z, r_w, ok, saturated, output ready);
endinterface

[src/quaternion_arithmetic_unit.sv]
// channel   dir  handshake      word
// in_ch     in   valid/ready    opcode, a_x..a_w, b_x..b_w (Q15.16)
// out_ch    out  valid/ready    r_x..r_w, ok, saturated
// cfg_*     in   cfg_we only    cfg_index, cfg_data (no read-back)
//
// one word accepted per cycle unless the pipe is stalled; a word reaches the output
// through 89 registers (input register + 5 multiply/sum stages + 49
// square-root stages + 1 divide setup + 32 divide stages + 1 output stage), fixed by
// the bit-per-stage root and quotient chains
// reset is synchronous: clears the valid bits and both config registers
// a stage holds only while it and every later stage is full and the output
// word is not taken; empty stages fill up, so bubbles collapse
module quaternion_arithmetic_unit import qau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  qau_in_if.sink            in_ch,
  qau_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  // widths of the internal values
  localparam int PW  = 2 * QW;        // raw product
  localparam int SW  = PW + 2;        // sum of four products, sum of squares
  localparam int RW  = 99;            // root remainder, holds S * 2^32
  localparam int RTW = 49;            // root of S * 2^32
  localparam int XW  = (2 * FRAC_BITS + 35 > 99) ? 2 * FRAC_BITS + 35 : 99;

  // stage map
  localparam int ST_IN   = 0;
  localparam int ST_MUL  = 1;
  localparam int ST_SUM  = 2;
  localparam int ST_MUL2 = 3;
  localparam int ST_T    = 4;
  localparam int ST_ROT  = 5;
  localparam int ST_SQ0  = 6;
  localparam int ST_DS   = ST_SQ0 + RTW;
  localparam int ST_DV0  = ST_DS + 1;
  localparam int ST_FIN  = ST_DV0 + QW;
  localparam int NST     = ST_FIN + 1;

  localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] SMAX = SW'(2147483647);
  localparam logic signed [SW-1:0] SMIN = ~SMAX;
  localparam logic [QW-1:0]        QMAX = 32'h7fffffff;
  localparam logic [QW-1:0]        QMIN = 32'h80000000;

  typedef struct packed {
    opcode_t               op;
    logic [3:0][QW-1:0]    a;     // x, y, z, w
    logic [3:0][QW-1:0]    b;
    logic [19:0][PW-1:0]   pr;    // products
    logic [3:0][QW-1:0]    r;     // early results, t for rotate
    logic                  sat;
    logic [2:0][QW-1:0]    u;     // q x v for rotate
    logic [SW-1:0]         s;     // sum of squares of a
    logic [RW-1:0]         rem;
    logic [RTW-1:0]        root;
    logic [XW-1:0]         dv;    // divisor base, S or root
    logic [3:0][XW-1:0]    rm;
    logic [3:0]            ovf;
    logic [3:0][QW-1:0]    q;
    logic                  ok;
  } pipe_t;

  function automatic logic [PW-1:0] mul(input logic [QW-1:0] x, input logic [QW-1:0] y);
    logic signed [PW-1:0] pm;
    pm = $signed(x) * $signed(y);
    return pm;
  endfunction

  function automatic logic signed [SW-1:0] ext(input logic [PW-1:0] p);
    return SW'($signed(p));
  endfunction

  // round to nearest, ties up, then clip to 32 bits; msb is the clip flag
  function automatic logic [QW:0] rsat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    t = (v + HALF) >>> FRAC_BITS;
    if (t > SMAX) return {1'b1, QMAX};
    else if (t < SMIN) return {1'b1, QMIN};
    else return {1'b0, t[QW-1:0]};
  endfunction

  // config registers
  logic [CFG_W-1:0] inv_min_r, norm_min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_min_r  <= '0;
      norm_min_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INV_MIN:  inv_min_r  <= cfg_data;
        CFG_NORM_MIN: norm_min_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // flow control: a stage loads when it or any later stage is empty, or the output word is taken
  logic [NST-1:0] v_r, v_nxt;
  logic [NST-1:0] en;
  pipe_t          stage [NST];

  for (genvar k = 0; k < NST; k++) begin : g_ctl
    assign en[k] = out_ch.ready | ~(&v_r[NST-1:k]);
    if (k == 0) begin : g_first
      assign v_nxt[k] = en[k] ? in_ch.valid : v_r[k];
    end else begin : g_rest
      assign v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= v_nxt;
  end

  assign in_ch.ready = en[0];

  // datapath stages
  for (genvar k = 0; k < NST; k++) begin : g_st
    pipe_t stg_nxt, stg_r;

    always_ff @(posedge clk) begin
      if (en[k]) stg_r <= stg_nxt;
    end
    assign stage[k] = stg_r;

    if (k == ST_IN) begin : g_in
      always_comb begin
        stg_nxt    = '0;
        stg_nxt.op = opcode_t'(in_ch.opcode);
        stg_nxt.a  = {in_ch.a_w, in_ch.a_z, in_ch.a_y, in_ch.a_x};
        stg_nxt.b  = {in_ch.b_w, in_ch.b_z, in_ch.b_y, in_ch.b_x};
      end
    end else if (k == ST_MUL) begin : g_mul
      // hamilton terms, with the rotate cross terms among them, and the squares of a
      always_comb begin
        stg_nxt = stage[k-1];
        stg_nxt.pr[0]  = mul(stage[k-1].a[3], stage[k-1].b[0]);
        stg_nxt.pr[1]  = mul(stage[k-1].a[0], stage[k-1].b[3]);
        stg_nxt.pr[2]  = mul(stage[k-1].a[1], stage[k-1].b[2]);
        stg_nxt.pr[3]  = mul(stage[k-1].a[2], stage[k-1].b[1]);
        stg_nxt.pr[4]  = mul(stage[k-1].a[3], stage[k-1].b[1]);
        stg_nxt.pr[5]  = mul(stage[k-1].a[0], stage[k-1].b[2]);
        stg_nxt.pr[6]  = mul(stage[k-1].a[1], stage[k-1].b[3]);
        stg_nxt.pr[7]  = mul(stage[k-1].a[2], stage[k-1].b[0]);
        stg_nxt.pr[8]  = mul(stage[k-1].a[3], stage[k-1].b[2]);
        stg_nxt.pr[9]  = mul(stage[k-1].a[0], stage[k-1].b[1]);
        stg_nxt.pr[10] = mul(stage[k-1].a[1], stage[k-1].b[0]);
        stg_nxt.pr[11] = mul(stage[k-1].a[2], stage[k-1].b[3]);
        stg_nxt.pr[12] = mul(stage[k-1].a[3], stage[k-1].b[3]);
        stg_nxt.pr[13] = mul(stage[k-1].a[0], stage[k-1].b[0]);
        stg_nxt.pr[14] = mul(stage[k-1].a[1], stage[k-1].b[1]);
        stg_nxt.pr[15] = mul(stage[k-1].a[2], stage[k-1].b[2]);
        for (int i = 0; i < 4; i++) begin
          stg_nxt.pr[16+i] = mul(stage[k-1].a[i], stage[k-1].a[i]);
        end
      end
    end else if (k == ST_SUM) begin : g_sum
      logic signed [SW-1:0] hs [4];
      logic signed [SW-1:0] cu [3];
      logic [QW:0]          rs;
      pipe_t                p;
      always_comb begin
        p       = stage[k-1];
        stg_nxt = p;
        rs      = '0;
        hs[0] = ext(p.pr[0]) + ext(p.pr[1]) + ext(p.pr[2]) - ext(p.pr[3]);
        hs[1] = ext(p.pr[4]) - ext(p.pr[5]) + ext(p.pr[6]) + ext(p.pr[7]);
        hs[2] = ext(p.pr[8]) + ext(p.pr[9]) - ext(p.pr[10]) + ext(p.pr[11]);
        hs[3] = ext(p.pr[12]) - ext(p.pr[13]) - ext(p.pr[14]) - ext(p.pr[15]);
        cu[0] = ext(p.pr[2]) - ext(p.pr[3]);
        cu[1] = ext(p.pr[7]) - ext(p.pr[5]);
        cu[2] = ext(p.pr[9]) - ext(p.pr[10]);
        stg_nxt.s = ext(p.pr[16]) + ext(p.pr[17]) + ext(p.pr[18]) + ext(p.pr[19]);
        case (p.op)
          OP_MUL: begin
            for (int i = 0; i < 4; i++) begin
              rs             = rsat(hs[i]);
              stg_nxt.r[i]   = rs[QW-1:0];
              stg_nxt.sat    = stg_nxt.sat | rs[QW];
            end
          end
          OP_CONJ: begin
            for (int i = 0; i < 3; i++) begin
              if (p.a[i] == QMIN) begin
                stg_nxt.r[i] = QMAX;
                stg_nxt.sat  = 1'b1;
              end else begin
                stg_nxt.r[i] = -p.a[i];
              end
            end
            stg_nxt.r[3] = p.a[3];
          end
          OP_ROT: begin
            for (int i = 0; i < 3; i++) begin
              rs           = rsat(cu[i]);
              stg_nxt.u[i] = rs[QW-1:0];
              stg_nxt.sat  = stg_nxt.sat | rs[QW];
            end
          end
          default: ;
        endcase
      end
    end else if (k == ST_MUL2) begin : g_mul2
      // q x u terms and w * u
      always_comb begin
        stg_nxt = stage[k-1];
        stg_nxt.pr[0] = mul(stage[k-1].a[1], stage[k-1].u[2]);
        stg_nxt.pr[1] = mul(stage[k-1].a[2], stage[k-1].u[1]);
        stg_nxt.pr[2] = mul(stage[k-1].a[2], stage[k-1].u[0]);
        stg_nxt.pr[3] = mul(stage[k-1].a[0], stage[k-1].u[2]);
        stg_nxt.pr[4] = mul(stage[k-1].a[0], stage[k-1].u[1]);
        stg_nxt.pr[5] = mul(stage[k-1].a[1], stage[k-1].u[0]);
        for (int i = 0; i < 3; i++) begin
          stg_nxt.pr[6+i] = mul(stage[k-1].a[3], stage[k-1].u[i]);
        end
      end
    end else if (k == ST_T) begin : g_t
      logic [QW:0] rs;
      always_comb begin
        stg_nxt = stage[k-1];
        rs      = '0;
        if (stage[k-1].op == OP_ROT) begin
          for (int i = 0; i < 3; i++) begin
            rs           = rsat(ext(stage[k-1].pr[2*i]) - ext(stage[k-1].pr[2*i+1]));
            stg_nxt.r[i] = rs[QW-1:0];
            stg_nxt.sat  = stg_nxt.sat | rs[QW];
          end
        end
      end
    end else if (k == ST_ROT) begin : g_rot
      logic signed [SW-1:0] bt;
      logic [QW:0]          rs;
      always_comb begin
        stg_nxt = stage[k-1];
        bt      = '0;
        rs      = '0;
        // v + 2t + 2wu, rounded once
        if (stage[k-1].op == OP_ROT) begin
          for (int i = 0; i < 3; i++) begin
            bt = SW'($signed(stage[k-1].b[i])) + (SW'($signed(stage[k-1].r[i])) <<< 1);
            rs = rsat((bt <<< FRAC_BITS) + (ext(stage[k-1].pr[6+i]) <<< 1));
            stg_nxt.r[i] = rs[QW-1:0];
            stg_nxt.sat  = stg_nxt.sat | rs[QW];
          end
          stg_nxt.r[3] = '0;
        end
        stg_nxt.rem  = RW'(stage[k-1].s) << 32;
        stg_nxt.root = '0;
      end
    end else if (k < ST_DS) begin : g_sqrt
      // one root bit per stage, msb first
      localparam int BB = RTW - 1 - (k - ST_SQ0);
      logic [RW-1:0] trial;
      always_comb begin
        stg_nxt = stage[k-1];
        trial   = (RW'(stage[k-1].root) << (BB + 1)) + (RW'(1) << (2 * BB));
        if (stage[k-1].rem >= trial) begin
          stg_nxt.rem      = stage[k-1].rem - trial;
          stg_nxt.root[BB] = 1'b1;
        end
      end
    end else if (k == ST_DS) begin : g_dset
      // quotient = (2*|a|*scale + d) / (2d), which rounds half away from zero
      logic [XW-1:0] d;
      logic [XW-1:0] n;
      logic [QW-1:0] m;
      always_comb begin
        stg_nxt = stage[k-1];
        d = (stage[k-1].op == OP_INV) ? XW'(stage[k-1].s) : XW'(stage[k-1].root);
        n = '0;
        m = '0;
        stg_nxt.dv = d;
        stg_nxt.q  = '0;
        for (int i = 0; i < 4; i++) begin
          m = stage[k-1].a[i][QW-1] ? -stage[k-1].a[i] : stage[k-1].a[i];
          if (stage[k-1].op == OP_INV) n = (XW'(m) << (2 * FRAC_BITS + 1)) + d;
          else                         n = (XW'(m) << (FRAC_BITS + 17)) + d;
          stg_nxt.rm[i]  = n;
          stg_nxt.ovf[i] = n >= (d << (QW + 1));
        end
        case (stage[k-1].op)
          OP_MUL, OP_CONJ, OP_ROT: stg_nxt.ok = 1'b1;
          OP_INV:  stg_nxt.ok = !(stage[k-1].s == '0 ||
                                  stage[k-1].s < (SW'(inv_min_r) << FRAC_BITS));
          OP_NORM: stg_nxt.ok = !(stage[k-1].root == '0 ||
                                  stage[k-1].root < (RTW'(norm_min_r) << 16));
          default: stg_nxt.ok = 1'b0;
        endcase
      end
    end else if (k < ST_FIN) begin : g_div
      // one quotient bit per stage for all four lanes
      localparam int JB = QW - 1 - (k - ST_DV0);
      logic [XW-1:0] tr;
      always_comb begin
        stg_nxt = stage[k-1];
        tr      = stage[k-1].dv << (JB + 1);
        for (int i = 0; i < 4; i++) begin
          if (stage[k-1].rm[i] >= tr) begin
            stg_nxt.rm[i]    = stage[k-1].rm[i] - tr;
            stg_nxt.q[i][JB] = 1'b1;
          end
        end
      end
    end else begin : g_fin
      logic  neg;
      pipe_t p;
      always_comb begin
        p       = stage[k-1];
        stg_nxt = p;
        neg     = 1'b0;
        if (p.op == OP_INV || p.op == OP_NORM) begin
          for (int i = 0; i < 4; i++) begin
            if (p.op == OP_INV && i < 3) neg = !p.a[i][QW-1] && p.a[i] != '0;
            else                         neg = p.a[i][QW-1];
            if (neg) begin
              if (p.ovf[i] || p.q[i] > QMIN) begin
                stg_nxt.r[i] = QMIN;
                stg_nxt.sat  = 1'b1;
              end else begin
                stg_nxt.r[i] = -p.q[i];
              end
            end else if (p.ovf[i] || p.q[i][QW-1]) begin
              stg_nxt.r[i] = QMAX;
              stg_nxt.sat  = 1'b1;
            end else begin
              stg_nxt.r[i] = p.q[i];
            end
          end
        end
        // refused or unknown opcode: echo a
        if (!p.ok) begin
          stg_nxt.r   = p.a;
          stg_nxt.sat = 1'b0;
        end
      end
    end
  end

  // output register is the last stage
  assign out_ch.valid     = v_r[ST_FIN];
  assign out_ch.r_x       = stage[ST_FIN].r[0];
  assign out_ch.r_y       = stage[ST_FIN].r[1];
  assign out_ch.r_z       = stage[ST_FIN].r[2];
  assign out_ch.r_w       = stage[ST_FIN].r[3];
  assign out_ch.ok        = stage[ST_FIN].ok;
  assign out_ch.saturated = stage[ST_FIN].sat;

  // checks
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!v_r[ST_FIN] || out_ch.ready) |-> in_ch.ready)
    else $error("input stalled with a free output stage");

  a_refuse_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ok) |-> !out_ch.saturated)
    else $error("refused word flagged saturated");

  a_rot_w: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && stage[ST_FIN].op == OP_ROT) |-> (out_ch.r_w == '0 && out_ch.ok))
    else $error("rotate word with nonzero w or not ok");

  a_bad_op: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && stage[ST_FIN].op != OP_MUL && stage[ST_FIN].op != OP_CONJ &&
     stage[ST_FIN].op != OP_INV && stage[ST_FIN].op != OP_NORM &&
     stage[ST_FIN].op != OP_ROT) |-> (!out_ch.ok && out_ch.r_x == stage[ST_FIN].a[0]))
    else $error("unknown opcode not echoed");

endmodule

[sim/tb_quaternion_arithmetic_unit.sv]
`timescale 1ns / 100ps

module tb_quaternion_arithmetic_unit;
  import qau_pkg::*;

  localparam int FRAC      = FRAC_BITS_DEF;
  localparam int LATENCY   = 89;     // pipeline depth from the port list header
  localparam int TAIL      = LATENCY + 20;
  localparam int WATCHDOG  = 5000;   // cycles without any handshake
  localparam int PHASE_ITEMS = 325;

  typedef logic signed [127:0] swide_t;
  typedef logic [127:0]        uwide_t;
  typedef logic signed [QW-1:0] comp_t;

  typedef struct {
    logic [OPW-1:0] opcode;
    comp_t          a [4];  // x, y, z, w
    comp_t          b [4];
  } quat_word_t;

  typedef struct {
    comp_t r [4];
    logic  ok;
    logic  saturated;
  } quat_result_t;

  // expected results in order, plus the predictor and its copy of the registers
  class qau_scoreboard;
    quat_result_t pending_results [$];
    logic [CFG_W-1:0] inv_min_norm_sq;
    logic [CFG_W-1:0] norm_min_norm;
    int errors, results_seen, refused_seen, clipped_seen;
    int op_count [8];

    function new();
      inv_min_norm_sq = '0;
      norm_min_norm   = '0;
    endfunction

    function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_INV_MIN) inv_min_norm_sq = data;
      else if (idx == CFG_NORM_MIN) norm_min_norm = data;
    endfunction

    function comp_t clip32(swide_t v, inout logic sat);
      if (v > swide_t'(32'sh7fffffff)) begin
        sat = 1'b1;
        return 32'sh7fffffff;
      end
      if (v < -swide_t'(64'sh80000000)) begin
        sat = 1'b1;
        return 32'sh80000000;
      end
      return comp_t'(v);
    endfunction

    // round half up at the binary point, then clip
    function comp_t round_clip(swide_t v, inout logic sat);
      return clip32((v + (swide_t'(1) <<< (FRAC - 1))) >>> FRAC, sat);
    endfunction

    function comp_t cross_term(comp_t p, comp_t q, comp_t r, comp_t s, inout logic sat);
      return round_clip(swide_t'(p) * swide_t'(q) - swide_t'(r) * swide_t'(s), sat);
    endfunction

    // round(mag * 2^shift / d), ties away from zero, signed and clipped
    function comp_t scaled_quot(uwide_t mag, int shift, uwide_t d, logic neg,
                                inout logic sat);
      uwide_t q;
      q = (((mag << shift) << 1) + d) / (d << 1);
      if (neg) begin
        if (q > 128'h80000000) begin
          sat = 1'b1;
          return 32'sh80000000;
        end
        return comp_t'(-swide_t'(q));
      end
      if (q > 128'h7fffffff) begin
        sat = 1'b1;
        return 32'sh7fffffff;
      end
      return comp_t'(q);
    endfunction

    function uwide_t floor_sqrt(uwide_t v);
      uwide_t res, c;
      res = '0;
      for (int bit_i = 48; bit_i >= 0; bit_i--) begin
        c = res | (uwide_t'(1) << bit_i);
        if (c * c <= v) res = c;
      end
      return res;
    endfunction

    function uwide_t magnitude(comp_t v);
      return (v < 0) ? uwide_t'(-swide_t'(v)) : uwide_t'(swide_t'(v));
    endfunction

    function quat_result_t compute_result(quat_word_t w);
      quat_result_t res;
      swide_t p [4][4];
      uwide_t norm_sq, root;
      comp_t u [3], t [3];
      logic sat, ok;
      sat = 1'b0;
      ok  = 1'b1;
      res.r = w.a;
      norm_sq = '0;
      for (int i = 0; i < 4; i++) norm_sq += magnitude(w.a[i]) * magnitude(w.a[i]);
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 4; j++) p[i][j] = swide_t'(w.a[i]) * swide_t'(w.b[j]);
      case (w.opcode)
        OP_MUL: begin
          res.r[0] = round_clip(p[3][0] + p[0][3] + p[1][2] - p[2][1], sat);
          res.r[1] = round_clip(p[3][1] - p[0][2] + p[1][3] + p[2][0], sat);
          res.r[2] = round_clip(p[3][2] + p[0][1] - p[1][0] + p[2][3], sat);
          res.r[3] = round_clip(p[3][3] - p[0][0] - p[1][1] - p[2][2], sat);
        end
        OP_CONJ: begin
          for (int i = 0; i < 3; i++) res.r[i] = clip32(-swide_t'(w.a[i]), sat);
        end
        OP_INV: begin
          if (norm_sq == 0 || norm_sq < (uwide_t'(inv_min_norm_sq) << FRAC)) begin
            ok = 1'b0;
          end else begin
            for (int i = 0; i < 3; i++)
              res.r[i] = scaled_quot(magnitude(w.a[i]), 2 * FRAC, norm_sq, w.a[i] > 0, sat);
            res.r[3] = scaled_quot(magnitude(w.a[3]), 2 * FRAC, norm_sq, w.a[3] < 0, sat);
          end
        end
        OP_NORM: begin
          root = floor_sqrt(norm_sq << 32);
          if (root == 0 || root < (uwide_t'(norm_min_norm) << 16)) begin
            ok = 1'b0;
          end else begin
            for (int i = 0; i < 4; i++)
              res.r[i] = scaled_quot(magnitude(w.a[i]), FRAC + 16, root, w.a[i] < 0, sat);
          end
        end
        OP_ROT: begin
          u[0] = cross_term(w.a[1], w.b[2], w.a[2], w.b[1], sat);
          u[1] = cross_term(w.a[2], w.b[0], w.a[0], w.b[2], sat);
          u[2] = cross_term(w.a[0], w.b[1], w.a[1], w.b[0], sat);
          t[0] = cross_term(w.a[1], u[2], w.a[2], u[1], sat);
          t[1] = cross_term(w.a[2], u[0], w.a[0], u[2], sat);
          t[2] = cross_term(w.a[0], u[1], w.a[1], u[0], sat);
          for (int i = 0; i < 3; i++)
            res.r[i] = round_clip(((swide_t'(w.b[i]) + 2 * swide_t'(t[i])) <<< FRAC)
                                  + 2 * swide_t'(w.a[3]) * swide_t'(u[i]), sat);
          res.r[3] = '0;
        end
        default: ok = 1'b0;
      endcase
      if (!ok) begin
        res.r = w.a;
        sat   = 1'b0;
      end
      res.ok        = ok;
      res.saturated = sat;
      return res;
    endfunction

    function void note_word(quat_word_t w);
      op_count[w.opcode]++;
      pending_results.push_back(compute_result(w));
    endfunction

    function void check_word(quat_result_t got);
      quat_result_t exp_r;
      string comp_name [4];
      comp_name = '{"r_x", "r_y", "r_z", "r_w"};
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (!exp_r.ok) refused_seen++;
      if (exp_r.saturated) clipped_seen++;
      for (int i = 0; i < 4; i++)
        if (got.r[i] !== exp_r.r[i]) begin
          $error("%s expected %0d got %0d", comp_name[i], exp_r.r[i], got.r[i]);
          errors++;
        end
      if (got.ok !== exp_r.ok) begin
        $error("ok expected %0d got %0d", exp_r.ok, got.ok);
        errors++;
      end
      if (got.saturated !== exp_r.saturated) begin
        $error("saturated expected %0d got %0d", exp_r.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  qau_in_if  in_ch ();
  qau_out_if out_ch ();

  qau_scoreboard sb = new();

  int send_idle_pct = 0;  // chance per cycle that the sender holds back
  int recv_idle_pct = 0;  // chance per cycle that the receiver stalls
  int quiet_cycles  = 0;

  quaternion_arithmetic_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // known values on every input from time zero
  initial begin
    in_ch.valid  = 1'b0;
    in_ch.opcode = OP_MUL;
    in_ch.a_x = '0; in_ch.a_y = '0; in_ch.a_z = '0; in_ch.a_w = '0;
    in_ch.b_x = '0; in_ch.b_y = '0; in_ch.b_z = '0; in_ch.b_w = '0;
    out_ch.ready = 1'b0;
  end

  // receiver side: random stalls at the rate of the current phase
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // input word accepted: predict its result
  always @(posedge clk) begin
    quat_word_t w;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      w.opcode = in_ch.opcode;
      w.a = '{in_ch.a_x, in_ch.a_y, in_ch.a_z, in_ch.a_w};
      w.b = '{in_ch.b_x, in_ch.b_y, in_ch.b_z, in_ch.b_w};
      sb.note_word(w);
    end
  end

  // result word accepted: compare against the oldest prediction
  always @(posedge clk) begin
    quat_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.r = '{out_ch.r_x, out_ch.r_y, out_ch.r_z, out_ch.r_w};
      got.ok = out_ch.ok;
      got.saturated = out_ch.saturated;
      sb.check_word(got);
    end
  end

  // watchdog: too long without any handshake on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // one word onto the input channel, with random gaps before it
  task automatic send_word(quat_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= w.opcode;
    in_ch.a_x <= w.a[0]; in_ch.a_y <= w.a[1]; in_ch.a_z <= w.a[2]; in_ch.a_w <= w.a[3];
    in_ch.b_x <= w.b[0]; in_ch.b_y <= w.b[1]; in_ch.b_z <= w.b[2]; in_ch.b_w <= w.b[3];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // wait for every outstanding result, then let the pipe settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
  endtask

  // both registers written back to back, block idle
  task automatic write_thresholds(logic [CFG_W-1:0] inv_min, logic [CFG_W-1:0] norm_min);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INV_MIN;
    cfg_data  <= inv_min;
    sb.write_reg(CFG_INV_MIN, inv_min);
    @(posedge clk);
    cfg_index <= CFG_NORM_MIN;
    cfg_data  <= norm_min;
    sb.write_reg(CFG_NORM_MIN, norm_min);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // components: full range, unit-ish, tiny, an extreme, or zero
  function automatic comp_t rand_comp();
    case ($urandom_range(9))
      0, 1, 2: return comp_t'($urandom);
      3, 4, 5: return comp_t'($signed($urandom_range(262144)) - 131072);
      6:       return comp_t'($signed($urandom_range(600)) - 300);
      7:       return 32'sh80000000;
      8:       return 32'sh7fffffff;
      default: return '0;
    endcase
  endfunction

  function automatic quat_word_t rand_word();
    quat_word_t w;
    int shape;
    // mostly valid opcodes, a few out of range
    w.opcode = ($urandom_range(19) == 0) ? OPW'($urandom_range(7))
                                         : OPW'($urandom_range(OP_ROT));
    shape = $urandom_range(3);
    for (int i = 0; i < 4; i++) begin
      w.a[i] = rand_comp();
      w.b[i] = rand_comp();
      // some words with A all tiny, to hit the refusal thresholds
      if (shape == 0) w.a[i] = comp_t'($signed($urandom_range(131072)) - 65536);
    end
    if (shape == 1 && $urandom_range(3) == 0) w.a = '{default: '0};
    return w;
  endfunction

  function automatic quat_word_t make_word(logic [OPW-1:0] op, comp_t ax, comp_t ay,
                                           comp_t az, comp_t aw, comp_t bv);
    quat_word_t w;
    w.opcode = op;
    w.a = '{ax, ay, az, aw};
    w.b = '{bv, bv, -bv, bv};
    return w;
  endfunction

  task automatic run_directed();
    comp_t mx, mn, one;
    mx  = 32'sh7fffffff;
    mn  = 32'sh80000000;
    one = 32'sh00010000;
    send_word(make_word(OP_MUL, one, '0, '0, one, one));
    send_word(make_word(OP_MUL, mx, mx, mx, mx, mx));      // clips
    send_word(make_word(OP_MUL, mn, mn, mn, mn, mn));
    send_word(make_word(OP_MUL, mn, mx, '0, -1, mx));
    send_word(make_word(OP_CONJ, mn, mn, mn, mn, '0));     // negating most negative
    send_word(make_word(OP_CONJ, mx, -1, '0, mn, '0));
    send_word(make_word(OP_INV, '0, '0, '0, '0, '0));      // zero quaternion refused
    send_word(make_word(OP_INV, '0, '0, '0, one, '0));
    send_word(make_word(OP_INV, '0, '0, 1, '0, '0));       // tiny norm, huge inverse
    send_word(make_word(OP_INV, mn, mx, mn, mx, '0));
    send_word(make_word(OP_INV, one, -one, one, -one, '0));
    send_word(make_word(OP_NORM, '0, '0, '0, '0, '0));     // zero quaternion refused
    send_word(make_word(OP_NORM, 1, '0, '0, '0, '0));
    send_word(make_word(OP_NORM, mn, mn, mn, mn, '0));
    send_word(make_word(OP_NORM, mx, '0, -3, 5, '0));
    send_word(make_word(OP_ROT, '0, '0, '0, one, one));
    send_word(make_word(OP_ROT, '0, '0, 32'sh0000b505, 32'sh0000b505, one));
    send_word(make_word(OP_ROT, mx, mn, mx, mn, mx));      // clipped intermediates
    send_word(make_word(OP_ROT, mn, mn, mn, mx, mn));
    send_word(make_word(3'd5, one, 2, 3, 4, one));         // out-of-range opcodes
    send_word(make_word(3'd6, mn, mx, '0, -1, '0));
    send_word(make_word(3'd7, -1, -1, -1, -1, -1));
  endtask

  initial begin
    logic [CFG_W-1:0] inv_set [4];
    logic [CFG_W-1:0] norm_set [4];
    inv_set  = '{16'd0, 16'hffff, CFG_W'($urandom_range(65535)), 16'd1};
    norm_set = '{16'd0, 16'hffff, CFG_W'($urandom_range(65535)), 16'd1};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      // receiver sparse first, then sender sparse, then free running
      case (phase)
        0: begin send_idle_pct = 21; recv_idle_pct = 79; end
        1: begin send_idle_pct = 79; recv_idle_pct = 21; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_thresholds(inv_set[phase], norm_set[phase]);
      if (phase == 0 || phase == 1) run_directed();
      for (int n = 0; n < PHASE_ITEMS; n++) send_word(rand_word());
      drain();
    end

    $display("covered %0d results: mul %0d conj %0d inv %0d norm %0d rot %0d bad-op %0d",
             sb.results_seen, sb.op_count[OP_MUL], sb.op_count[OP_CONJ],
             sb.op_count[OP_INV], sb.op_count[OP_NORM], sb.op_count[OP_ROT],
             sb.op_count[5] + sb.op_count[6] + sb.op_count[7]);
    $display("refused %0d, clipped %0d, four threshold settings incl. both extremes",
             sb.refused_seen, sb.clipped_seen);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
